/* design/rssc_pkg.sv */
// rssc_pkg: shared types and constants for the radio scan and seek controller
// band limits, mode codes, opcodes, register indexes and the configuration struct
// no dependencies
package rssc_pkg;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_SCAN = 2'd1,
		MODE_UP   = 2'd2,
		MODE_DOWN = 2'd3
	} mode_t;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_BAND_IS_AM   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FREQ_STEP    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TICKS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_AM_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FM_THRESHOLD = 3'd4;

	localparam int unsigned AM_MIN    = 540000;
	localparam int unsigned AM_MAX    = 1700000;
	localparam int unsigned FM_MIN    = 87900000;
	localparam int unsigned FM_MAX    = 107900000;
	localparam int unsigned AM_OFFSET = 125000000;

	// band constants need 27 bits plus room for sign and carry
	localparam int unsigned BAND_BITS = 27;

	localparam logic [23:0]        RST_FREQ_STEP    = 24'd200000;
	localparam logic [15:0]        RST_SETTLE_TICKS = 16'd500;
	localparam logic signed [15:0] RST_AM_THRESHOLD = 16'sd768;
	localparam logic signed [15:0] RST_FM_THRESHOLD = 16'sd2048;

	typedef struct packed {
		logic               band_is_am;
		logic [23:0]        freq_step;
		logic [15:0]        settle_ticks;
		logic signed [15:0] am_threshold;
		logic signed [15:0] fm_threshold;
	} cfg_t;

endpackage

/* design/rssc_cfg.sv */
// rssc_cfg: configuration register file, write only
// uses rssc_pkg for register indexes, reset values and cfg_t
module rssc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [rssc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [rssc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output rssc_pkg::cfg_t                      cfg
);

	rssc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_is_am   <= 1'b0;
			cfg_q.freq_step    <= rssc_pkg::RST_FREQ_STEP;
			cfg_q.settle_ticks <= rssc_pkg::RST_SETTLE_TICKS;
			cfg_q.am_threshold <= rssc_pkg::RST_AM_THRESHOLD;
			cfg_q.fm_threshold <= rssc_pkg::RST_FM_THRESHOLD;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rssc_pkg::REG_BAND_IS_AM:   cfg_q.band_is_am   <= cfg_data[0];
				rssc_pkg::REG_FREQ_STEP:    cfg_q.freq_step    <= cfg_data[23:0];
				rssc_pkg::REG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data[15:0];
				rssc_pkg::REG_AM_THRESHOLD: cfg_q.am_threshold <= $signed(cfg_data[15:0]);
				rssc_pkg::REG_FM_THRESHOLD: cfg_q.fm_threshold <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/rssc_step.sv */
// rssc_step: controller state and the one-pass step logic for a command or tick
// uses rssc_pkg for mode codes, opcodes, band constants and cfg_t
module rssc_step #(
	parameter int FREQ_BITS   = 27,
	parameter int SETTLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  rssc_pkg::cfg_t        cfg,
	input  logic                  opcode,
	input  logic [1:0]            new_mode,
	input  logic [FREQ_BITS-1:0]  current_freq,
	input  logic signed [15:0]    snr_db,
	output logic                  retune_valid,
	output logic [FREQ_BITS-1:0]  demod_freq,
	output logic [FREQ_BITS-1:0]  tuner_freq,
	output logic [1:0]            mode_now,
	output logic                  station_valid,
	output logic [FREQ_BITS-1:0]  station_freq
);

	localparam int CW = ((FREQ_BITS > rssc_pkg::BAND_BITS) ? FREQ_BITS
		: rssc_pkg::BAND_BITS) + 2;
	localparam int SW = (SETTLE_BITS > 16) ? SETTLE_BITS : 16;

	rssc_pkg::mode_t        mode_q, mode_d;
	logic                   started_q, started_d;
	logic [FREQ_BITS-1:0]   start_freq_q, start_freq_d;
	logic                   found_valid_q, found_valid_d;
	logic [FREQ_BITS-1:0]   found_freq_q, found_freq_d;
	logic [SETTLE_BITS-1:0] settle_q, settle_d;

	logic                   settle_sat;
	logic [SETTLE_BITS-1:0] settle_inc;
	logic                   settle_ok;
	logic signed [CW-1:0]   cur_w, start_w, step_w, min_w, max_w, nx_w, next_w, tuner_w;
	logic signed [15:0]     thr;
	logic                   station;
	logic                   wrapped;
	logic                   retune;

	assign settle_sat = (settle_q == {SETTLE_BITS{1'b1}});
	assign settle_inc = settle_sat ? settle_q : settle_q + 1'b1;
	assign settle_ok  = (SW'(settle_inc) >= SW'(cfg.settle_ticks))
		|| (settle_inc == {SETTLE_BITS{1'b1}});

	assign cur_w   = $signed({{(CW-FREQ_BITS){1'b0}}, current_freq});
	assign start_w = $signed({{(CW-FREQ_BITS){1'b0}}, start_freq_q});
	assign step_w  = $signed({{(CW-24){1'b0}}, cfg.freq_step});
	assign min_w   = cfg.band_is_am ? $signed(CW'(rssc_pkg::AM_MIN))
		: $signed(CW'(rssc_pkg::FM_MIN));
	assign max_w   = cfg.band_is_am ? $signed(CW'(rssc_pkg::AM_MAX))
		: $signed(CW'(rssc_pkg::FM_MAX));
	assign thr     = cfg.band_is_am ? cfg.am_threshold : cfg.fm_threshold;
	assign station = (snr_db >= thr);

	always_comb begin
		wrapped = 1'b0;
		if (mode_q == rssc_pkg::MODE_DOWN) begin
			nx_w = cur_w - step_w;
			if (nx_w < min_w) begin
				wrapped = 1'b1;
				nx_w = max_w;
			end
		end else begin
			nx_w = cur_w + step_w;
			if (nx_w > max_w) begin
				wrapped = 1'b1;
				nx_w = min_w;
			end
		end
	end

	always_comb begin
		mode_d        = mode_q;
		started_d     = started_q;
		start_freq_d  = start_freq_q;
		found_valid_d = found_valid_q;
		found_freq_d  = found_freq_q;
		settle_d      = settle_q;
		retune        = 1'b0;
		if (opcode == rssc_pkg::OP_SET) begin
			mode_d        = rssc_pkg::mode_t'(new_mode);
			started_d     = 1'b0;
			found_valid_d = 1'b0;
			found_freq_d  = '0;
		end else begin
			settle_d = settle_inc;
			if (mode_q != rssc_pkg::MODE_OFF) begin
				if (!started_q) begin
					start_freq_d = current_freq;
					started_d    = 1'b1;
				end else if (settle_ok) begin
					settle_d = '0;
					if (mode_q == rssc_pkg::MODE_SCAN) begin
						if (station) begin
							found_valid_d = 1'b1;
							found_freq_d  = current_freq;
						end
						if ((wrapped || (current_freq < start_freq_q)) && (start_w <= nx_w)) begin
							mode_d = rssc_pkg::MODE_OFF;
						end
						retune = 1'b1;
					end else if (station && ((current_freq != start_freq_q) || wrapped)) begin
						found_valid_d = 1'b1;
						found_freq_d  = current_freq;
						mode_d        = rssc_pkg::MODE_OFF;
					end else begin
						retune = 1'b1;
					end
				end
			end
		end
	end

	assign next_w  = retune ? nx_w : '0;
	assign tuner_w = next_w + ((retune && cfg.band_is_am) ? $signed(CW'(rssc_pkg::AM_OFFSET))
		: $signed(CW'(0)));

	assign retune_valid  = retune;
	assign demod_freq    = next_w[FREQ_BITS-1:0];
	assign tuner_freq    = tuner_w[FREQ_BITS-1:0];
	assign mode_now      = mode_d;
	assign station_valid = found_valid_d;
	assign station_freq  = found_valid_d ? found_freq_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= rssc_pkg::MODE_OFF;
			started_q     <= 1'b0;
			start_freq_q  <= '0;
			found_valid_q <= 1'b0;
			found_freq_q  <= '0;
			settle_q      <= {SETTLE_BITS{1'b1}};
		end else if (en) begin
			mode_q        <= mode_d;
			started_q     <= started_d;
			start_freq_q  <= start_freq_d;
			found_valid_q <= found_valid_d;
			found_freq_q  <= found_freq_d;
			settle_q      <= settle_d;
		end
	end

endmodule

/* design/radio_scan_seek_controller_unit.sv */
// radio scan and seek controller: input register, step logic, result register
// path: an input transfer fills the input register, then the result register; a stall holds either
// throughput: one item per cycle while the output is not stalled
// the result register frees as it is taken, so input and output move together
// reset: arst_n resets state and configuration and clears both valid flags at once
module radio_scan_seek_controller_unit #(
	parameter int FREQ_BITS   = 27,
	parameter int SETTLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [rssc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [rssc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [1:0]                          new_mode,
	input  logic [FREQ_BITS-1:0]                current_freq,
	input  logic signed [15:0]                  snr_db,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                retune_valid,
	output logic [FREQ_BITS-1:0]                demod_freq,
	output logic [FREQ_BITS-1:0]                tuner_freq,
	output logic [1:0]                          mode_now,
	output logic                                station_valid,
	output logic [FREQ_BITS-1:0]                station_freq
);

	rssc_pkg::cfg_t cfg;

	logic                 valid_s1;
	logic                 opcode_s1;
	logic [1:0]           new_mode_s1;
	logic [FREQ_BITS-1:0] current_freq_s1;
	logic signed [15:0]   snr_db_s1;

	logic                 out_valid_q;
	logic                 retune_valid_q;
	logic [FREQ_BITS-1:0] demod_freq_q;
	logic [FREQ_BITS-1:0] tuner_freq_q;
	logic [1:0]           mode_now_q;
	logic                 station_valid_q;
	logic [FREQ_BITS-1:0] station_freq_q;

	logic                 adv;
	logic                 in_xfer;
	logic                 r_retune;
	logic [FREQ_BITS-1:0] r_demod;
	logic [FREQ_BITS-1:0] r_tuner;
	logic [1:0]           r_mode;
	logic                 r_station;
	logic [FREQ_BITS-1:0] r_station_freq;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	rssc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rssc_step #(
		.FREQ_BITS   (FREQ_BITS),
		.SETTLE_BITS (SETTLE_BITS)
	) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.cfg           (cfg),
		.opcode        (opcode_s1),
		.new_mode      (new_mode_s1),
		.current_freq  (current_freq_s1),
		.snr_db        (snr_db_s1),
		.retune_valid  (r_retune),
		.demod_freq    (r_demod),
		.tuner_freq    (r_tuner),
		.mode_now      (r_mode),
		.station_valid (r_station),
		.station_freq  (r_station_freq)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1       <= opcode;
			new_mode_s1     <= new_mode;
			current_freq_s1 <= current_freq;
			snr_db_s1       <= snr_db;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			retune_valid_q  <= r_retune;
			demod_freq_q    <= r_demod;
			tuner_freq_q    <= r_tuner;
			mode_now_q      <= r_mode;
			station_valid_q <= r_station;
			station_freq_q  <= r_station_freq;
		end
	end

	assign out_valid     = out_valid_q;
	assign retune_valid  = retune_valid_q;
	assign demod_freq    = demod_freq_q;
	assign tuner_freq    = tuner_freq_q;
	assign mode_now      = mode_now_q;
	assign station_valid = station_valid_q;
	assign station_freq  = station_freq_q;

endmodule

/* design/rssc_chk.sv */
// rssc_chk: port-level checks on the radio scan and seek controller
// bound to radio_scan_seek_controller_unit, sees its ports only
module rssc_chk #(
	parameter int FREQ_BITS = 27
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 retune_valid,
	input logic [FREQ_BITS-1:0] demod_freq,
	input logic [FREQ_BITS-1:0] tuner_freq,
	input logic [1:0]           mode_now,
	input logic                 station_valid,
	input logic [FREQ_BITS-1:0] station_freq
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(demod_freq) && $stable(tuner_freq)
			&& $stable(mode_now) && $stable(station_freq) && $stable(retune_valid))
		else $error("result payload changed while stalled");

	// no retune means both frequencies read zero
	a_no_retune_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !retune_valid |-> (demod_freq == '0) && (tuner_freq == '0))
		else $error("frequency shown without retune");

	// no station means station frequency reads zero
	a_no_station_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !station_valid |-> (station_freq == '0))
		else $error("station frequency shown without station");

endmodule

bind radio_scan_seek_controller_unit rssc_chk #(
	.FREQ_BITS (FREQ_BITS)
) u_rssc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.retune_valid  (retune_valid),
	.demod_freq    (demod_freq),
	.tuner_freq    (tuner_freq),
	.mode_now      (mode_now),
	.station_valid (station_valid),
	.station_freq  (station_freq)
);

/* sim/radio_scan_seek_controller_unit_test.sv */
// testbench for radio_scan_seek_controller_unit: directed and random commands and ticks
// with its own prediction of retunes, mode and found station, checked field by field
// depends on rssc_pkg and the controller rtl only
module radio_scan_seek_controller_unit_test;

	localparam int FB = 27;
	localparam int CLK_PERIOD = 12;

	typedef struct {
		logic          retune;
		logic [FB-1:0] demod;
		logic [FB-1:0] tuner;
		logic [1:0]    mode;
		logic          stn_v;
		logic [FB-1:0] stn_f;
	} tune_result_t;

	class seek_scoreboard;
		rssc_pkg::cfg_t  cfg;
		rssc_pkg::mode_t cur_mode;
		bit              armed;
		logic [FB-1:0]   origin_freq;
		bit              have_station;
		logic [FB-1:0]   station_at;
		logic [15:0]     ticks_since_tune;
		tune_result_t    expected_tunes[$];
		int unsigned     errors, compared, n_set, n_tick, n_retune, n_found, n_done, n_cfg;

		function new();
			cfg.band_is_am = 1'b0;
			cfg.freq_step = rssc_pkg::RST_FREQ_STEP;
			cfg.settle_ticks = rssc_pkg::RST_SETTLE_TICKS;
			cfg.am_threshold = rssc_pkg::RST_AM_THRESHOLD;
			cfg.fm_threshold = rssc_pkg::RST_FM_THRESHOLD;
			cur_mode = rssc_pkg::MODE_OFF;
			armed = 1'b0;
			origin_freq = '0;
			have_station = 1'b0;
			station_at = '0;
			ticks_since_tune = '1;
		endfunction

		function void set_reg(logic [rssc_pkg::CFG_IDX_BITS-1:0] idx,
				logic [rssc_pkg::CFG_DATA_BITS-1:0] d);
			case (idx)
				rssc_pkg::REG_BAND_IS_AM: cfg.band_is_am = d[0];
				rssc_pkg::REG_FREQ_STEP: cfg.freq_step = d[23:0];
				rssc_pkg::REG_SETTLE_TICKS: cfg.settle_ticks = d[15:0];
				rssc_pkg::REG_AM_THRESHOLD: cfg.am_threshold = d[15:0];
				rssc_pkg::REG_FM_THRESHOLD: cfg.fm_threshold = d[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_tunes.size();
		endfunction

		// predict the result of one transfer and queue it
		function tune_result_t accept_item(logic op, logic [1:0] sel_mode, logic [FB-1:0] fc,
				logic signed [15:0] snr);
			tune_result_t r;
			longint fmin, fmax, nx, sum;
			logic signed [15:0] thr;
			bit station, wrapped;
			r.retune = 1'b0;
			r.demod = '0;
			r.tuner = '0;
			if (op == rssc_pkg::OP_SET) begin
				cur_mode = rssc_pkg::mode_t'(sel_mode);
				armed = 1'b0;
				have_station = 1'b0;
				station_at = '0;
				n_set++;
			end else begin
				n_tick++;
				if (ticks_since_tune != '1)
					ticks_since_tune++;
				if (cur_mode != rssc_pkg::MODE_OFF) begin
					if (!armed) begin
						origin_freq = fc;
						armed = 1'b1;
					end else if (ticks_since_tune >= cfg.settle_ticks || ticks_since_tune == '1) begin
						fmin = cfg.band_is_am ? longint'(rssc_pkg::AM_MIN) : longint'(rssc_pkg::FM_MIN);
						fmax = cfg.band_is_am ? longint'(rssc_pkg::AM_MAX) : longint'(rssc_pkg::FM_MAX);
						thr = cfg.band_is_am ? cfg.am_threshold : cfg.fm_threshold;
						station = (snr >= thr);
						wrapped = 1'b0;
						ticks_since_tune = '0;
						if (cur_mode == rssc_pkg::MODE_DOWN) begin
							nx = longint'(fc) - longint'(cfg.freq_step);
							if (nx < fmin) begin
								wrapped = 1'b1;
								nx = fmax;
							end
						end else begin
							nx = longint'(fc) + longint'(cfg.freq_step);
							if (nx > fmax) begin
								wrapped = 1'b1;
								nx = fmin;
							end
						end
						if (cur_mode == rssc_pkg::MODE_SCAN) begin
							if (station) begin
								have_station = 1'b1;
								station_at = fc;
								n_found++;
							end
							// scan ends once its next step comes round to or past its origin
							if ((wrapped || fc < origin_freq) && longint'(origin_freq) <= nx) begin
								cur_mode = rssc_pkg::MODE_OFF;
								n_done++;
							end
							r.retune = 1'b1;
						end else if (station && (fc != origin_freq || wrapped)) begin
							have_station = 1'b1;
							station_at = fc;
							cur_mode = rssc_pkg::MODE_OFF;
							n_found++;
							n_done++;
						end else begin
							r.retune = 1'b1;
						end
						if (r.retune) begin
							sum = nx + (cfg.band_is_am ? longint'(rssc_pkg::AM_OFFSET) : 64'sd0);
							r.demod = nx[FB-1:0];
							r.tuner = sum[FB-1:0];
							n_retune++;
						end
					end
				end
			end
			r.mode = cur_mode;
			r.stn_v = have_station;
			r.stn_f = have_station ? station_at : '0;
			expected_tunes.push_back(r);
			return r;
		endfunction

		function void compare_field(string name, logic [FB-1:0] exp_v, logic [FB-1:0] got_v);
			if (got_v !== exp_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(tune_result_t got);
			tune_result_t want;
			if (expected_tunes.size() == 0) begin
				$error("result transfer with no expected result waiting");
				errors++;
				return;
			end
			want = expected_tunes.pop_front();
			compared++;
			compare_field("retune_valid", FB'(want.retune), FB'(got.retune));
			compare_field("demod_freq", want.demod, got.demod);
			compare_field("tuner_freq", want.tuner, got.tuner);
			compare_field("mode_now", FB'(want.mode), FB'(got.mode));
			compare_field("station_valid", FB'(want.stn_v), FB'(got.stn_v));
			compare_field("station_freq", want.stn_f, got.stn_f);
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_wr = 1'b0;
	logic [rssc_pkg::CFG_IDX_BITS-1:0]  cfg_idx = '0;
	logic [rssc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic                               opcode = rssc_pkg::OP_TICK;
	logic [1:0]                         new_mode = rssc_pkg::MODE_OFF;
	logic [FB-1:0]                      current_freq = '0;
	logic signed [15:0]                 snr_db = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic                               retune_valid;
	logic [FB-1:0]                      demod_freq;
	logic [FB-1:0]                      tuner_freq;
	logic [1:0]                         mode_now;
	logic                               station_valid;
	logic [FB-1:0]                      station_freq;

	seek_scoreboard sb;
	logic [FB-1:0]  tuned = FB'(rssc_pkg::FM_MIN);
	bit             calm = 1'b0;

	radio_scan_seek_controller_unit dut (.*);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// result side: bursts of stall, none once the run goes calm
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && arst_n && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_monitor
		tune_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.retune = retune_valid;
			got.demod = demod_freq;
			got.tuner = tuner_freq;
			got.mode = mode_now;
			got.stn_v = station_valid;
			got.stn_f = station_freq;
			sb.check_result(got);
		end
	end

	task automatic send(logic op, logic [1:0] sel_mode, logic [FB-1:0] fc, logic signed [15:0] snr);
		tune_result_t r;
		opcode <= op;
		new_mode <= sel_mode;
		current_freq <= fc;
		snr_db <= snr;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = sb.accept_item(op, sel_mode, fc, snr);
		// the tuner follows every retune
		if (r.retune === 1'b1)
			tuned = r.demod;
	endtask

	task automatic pause_sender(int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [rssc_pkg::CFG_IDX_BITS-1:0] idx,
			logic [rssc_pkg::CFG_DATA_BITS-1:0] d);
		cfg_wr <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
		cfg_wr <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits carry noise
	task automatic program_regs(logic band, logic [23:0] step, logic [15:0] settle,
			logic signed [15:0] am_thr, logic signed [15:0] fm_thr);
		logic [rssc_pkg::CFG_DATA_BITS-1:0] d;
		wait_for_results();
		d = rssc_pkg::CFG_DATA_BITS'($urandom);
		d[0] = band;
		write_reg(rssc_pkg::REG_BAND_IS_AM, d);
		write_reg(rssc_pkg::REG_FREQ_STEP, step);
		d = rssc_pkg::CFG_DATA_BITS'($urandom);
		d[15:0] = settle;
		write_reg(rssc_pkg::REG_SETTLE_TICKS, d);
		d = rssc_pkg::CFG_DATA_BITS'($urandom);
		d[15:0] = am_thr;
		write_reg(rssc_pkg::REG_AM_THRESHOLD, d);
		d = rssc_pkg::CFG_DATA_BITS'($urandom);
		d[15:0] = fm_thr;
		write_reg(rssc_pkg::REG_FM_THRESHOLD, d);
		sb.n_cfg++;
	endtask

	// mostly follows the tuner through proper mode sequences, with some noise
	task automatic issue_random_item();
		logic [1:0]         sel_mode;
		logic [FB-1:0]      f;
		logic signed [15:0] s;
		int                 thr_i, v;
		int unsigned        lo, hi, pick;
		lo = sb.cfg.band_is_am ? rssc_pkg::AM_MIN : rssc_pkg::FM_MIN;
		hi = sb.cfg.band_is_am ? rssc_pkg::AM_MAX : rssc_pkg::FM_MAX;
		sel_mode = 2'($urandom);
		f = FB'($urandom);
		s = 16'($urandom);
		if ((sb.cur_mode == rssc_pkg::MODE_OFF && $urandom_range(0, 3) != 0)
				|| $urandom_range(0, 29) == 0) begin
			sel_mode = ($urandom_range(0, 9) == 0) ? rssc_pkg::MODE_OFF : 2'($urandom_range(1, 3));
			if ($urandom_range(0, 1) == 1)
				tuned = FB'($urandom_range(hi, lo));
			send(rssc_pkg::OP_SET, sel_mode, f, s);
		end else begin
			pick = $urandom_range(0, 19);
			if (pick <= 14)
				f = tuned;
			else if (pick == 16)
				f = FB'(($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 2) - 1);
			else if (pick == 17)
				f = FB'($urandom_range(hi, lo));
			else if (pick == 18)
				f = tuned ^ (27'd1 << $urandom_range(0, FB - 1));
			else if (pick == 19)
				f = FB'($urandom_range(0, 2000000));
			thr_i = sb.cfg.band_is_am ? sb.cfg.am_threshold : sb.cfg.fm_threshold;
			pick = $urandom_range(0, 9);
			if (pick != 2) begin
				if (pick <= 1)
					v = thr_i + int'($urandom_range(0, 4)) - 2;
				else if (pick == 3)
					v = thr_i + int'($urandom_range(0, 3000));
				else
					v = thr_i - int'($urandom_range(1, 12000));
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				s = v[15:0];
			end
			send(rssc_pkg::OP_TICK, sel_mode, f, s);
		end
	endtask

	task automatic run_phase(logic band, logic [23:0] step, logic [15:0] settle,
			logic signed [15:0] am_thr, logic signed [15:0] fm_thr, int n);
		program_regs(band, step, settle, am_thr, fm_thr);
		for (int k = 0; k < n; k++) begin
			if (k == n / 2 && !calm)
				wait_for_results();
			if (!calm && $urandom_range(0, 9) == 0)
				pause_sender($urandom_range(1, 15));
			issue_random_item();
		end
	endtask

	initial begin
		#(CLK_PERIOD * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main_sequence
		int unsigned guard;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: settle counter starts saturated, so the first step acts at once
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, '1, 16'sh7FFF);
		send(rssc_pkg::OP_SET, rssc_pkg::MODE_UP, '0, 16'sh8000);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MAX), 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MAX), 16'sh8000);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MIN), 16'sh7FFF);

		program_regs(1'b0, 24'd200000, 16'd0, 16'sd768, 16'sd2048);
		// seek up stops on a station exactly at threshold
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MIN), 16'sd2048);
		// seek down wraps onto its own origin and stops there
		send(rssc_pkg::OP_SET, rssc_pkg::MODE_DOWN, '1, 16'sh7FFF);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MIN), 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MIN), 16'sh7FFF);
		// station on the origin without wrap is skipped
		send(rssc_pkg::OP_SET, rssc_pkg::MODE_UP, '0, 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, 27'd100000000, 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, 27'd100000000, 16'sh7FFF);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, 27'd100200000, 16'sd2047);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, 27'd100400000, 16'sd2048);
		// scan: log a station, wrap at the top, end after passing the origin
		send(rssc_pkg::OP_SET, rssc_pkg::MODE_SCAN, '0, 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MAX - 200000), 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MAX - 200000), 16'sd3000);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MAX), 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MAX - 400000), 16'sd0);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, FB'(rssc_pkg::FM_MIN), 16'sh7FFF);
		send(rssc_pkg::OP_SET, rssc_pkg::MODE_OFF, '1, 16'sh7FFF);
		send(rssc_pkg::OP_TICK, rssc_pkg::MODE_OFF, '0, 16'sh8000);

		run_phase(1'b0, 24'd1000000, 16'd0, 16'sh8000, 16'sd2048, 110);
		run_phase(1'b1, 24'd50000, 16'd1, 16'sd768, -16'sd1000, 110);
		run_phase(1'b0, 24'hFFFFFF, 16'd2, 16'sd0, 16'sh7FFF, 90);
		run_phase(1'b1, 24'd1, 16'd0, 16'sh7FFF, 16'sd0, 60);
		run_phase(1'b0, 24'd0, 16'd0, 16'sd100, 16'sh8000, 60);
		run_phase(1'b1, 24'd200000, 16'd3, 16'sh8000, 16'sd500, 100);
		run_phase(1'b0, 24'd500000, 16'hFFFF, 16'sd768, 16'sd2048, 40);
		run_phase(1'($urandom_range(0, 1)), 24'($urandom_range(300000, 3000000)),
			16'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 200);
		calm = 1'b1;
		run_phase(1'b1, 24'($urandom_range(20000, 200000)), 16'd0,
			16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)), 150);

		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end

		$display("covered %0d mode sets and %0d ticks over %0d register settings, %0d retunes",
			sb.n_set, sb.n_tick, sb.n_cfg, sb.n_retune);
		$display("%0d stations logged, %0d scans or seeks finished, %0d results compared",
			sb.n_found, sb.n_done, sb.compared);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
